>>> rtl/rdl_pkg.sv
`timescale 1ns / 1ps
package rdl_pkg;

    localparam int MAX_GROUP    = 64;
    localparam int CORDIC_STEPS = 16;

    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic [63:0] TWO_PI_Q28     = 64'd1686629713;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_GAP   = 2'd1;
    localparam logic [1:0] REG_CDIAG = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_SINGLE   = 5'd2;
    localparam logic [4:0] OP_MUL_ND   = 5'd3;
    localparam logic [4:0] OP_MUL_FIT  = 5'd4;
    localparam logic [4:0] OP_SET_R1   = 5'd5;
    localparam logic [4:0] OP_RING     = 5'd6;
    localparam logic [4:0] OP_MUL_CAP  = 5'd7;
    localparam logic [4:0] OP_CAP_CMP  = 5'd8;
    localparam logic [4:0] OP_CAP_STEP = 5'd9;
    localparam logic [4:0] OP_CAP_END  = 5'd10;
    localparam logic [4:0] OP_PHD_INIT = 5'd11;
    localparam logic [4:0] OP_PHD_STEP = 5'd12;
    localparam logic [4:0] OP_COR_INIT = 5'd13;
    localparam logic [4:0] OP_COR_STEP = 5'd14;
    localparam logic [4:0] OP_COR_END  = 5'd15;
    localparam logic [4:0] OP_MUL_PT   = 5'd16;
    localparam logic [4:0] OP_FIELD    = 5'd17;
    localparam logic [4:0] OP_ADVANCE  = 5'd18;

    typedef struct packed {
        logic [4:0] op;
        logic [4:0] step;
    } rdl_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic in_one;
        logic mode;
        logic d_zero;
        logic last_point;
        logic last_in_ring;
    } rdl_status_t;

    // arctangent in 2^-32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/rdl_ctrl.sv
`timescale 1ns / 1ps
module rdl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rdl_pkg::rdl_status_t st,
    output rdl_pkg::rdl_cmd_t   cmd
);
    import rdl_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SINGLE = 5'd1;
    localparam logic [4:0] ST_ND     = 5'd2;
    localparam logic [4:0] ST_FIT    = 5'd3;
    localparam logic [4:0] ST_SETR   = 5'd4;
    localparam logic [4:0] ST_RING   = 5'd5;
    localparam logic [4:0] ST_CAPM   = 5'd6;
    localparam logic [4:0] ST_CAPC   = 5'd7;
    localparam logic [4:0] ST_CAPS   = 5'd8;
    localparam logic [4:0] ST_CAPE   = 5'd9;
    localparam logic [4:0] ST_PHDI   = 5'd10;
    localparam logic [4:0] ST_PHD    = 5'd11;
    localparam logic [4:0] ST_CORI   = 5'd12;
    localparam logic [4:0] ST_COR    = 5'd13;
    localparam logic [4:0] ST_CORE   = 5'd14;
    localparam logic [4:0] ST_PM     = 5'd15;
    localparam logic [4:0] ST_PF     = 5'd16;
    localparam logic [4:0] ST_OUT    = 5'd17;

    localparam logic [4:0] COR_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] PHD_LAST = 5'd31;
    localparam logic [4:0] CAP_LAST = 5'd6;
    localparam logic [4:0] PT_LAST  = 5'd3;

    logic [4:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    if (st.in_zero) state_next = ST_IDLE;
                    else if (st.in_one) state_next = ST_SINGLE;
                    else if (st.mode) state_next = ST_RING;
                    else state_next = ST_ND;
                end
            end
            ST_SINGLE: begin
                cmd.op = OP_SINGLE;
                state_next = ST_OUT;
            end
            ST_ND: begin
                cmd.op = OP_MUL_ND;
                state_next = ST_FIT;
            end
            ST_FIT: begin
                cmd.op = OP_MUL_FIT;
                state_next = ST_SETR;
            end
            ST_SETR: begin
                cmd.op = OP_SET_R1;
                state_next = ST_PHDI;
            end
            ST_RING: begin
                cmd.op = OP_RING;
                state_next = st.d_zero ? ST_PHDI : ST_CAPM;
            end
            ST_CAPM: begin
                cmd.op = OP_MUL_CAP;
                state_next = ST_CAPC;
            end
            ST_CAPC: begin
                cmd.op = OP_CAP_CMP;
                step_next = '0;
                state_next = ST_CAPS;
            end
            ST_CAPS: begin
                cmd.op = OP_CAP_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == CAP_LAST) state_next = ST_CAPE;
            end
            ST_CAPE: begin
                cmd.op = OP_CAP_END;
                state_next = ST_PHDI;
            end
            ST_PHDI: begin
                cmd.op = OP_PHD_INIT;
                step_next = '0;
                state_next = ST_PHD;
            end
            ST_PHD: begin
                cmd.op = OP_PHD_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == PHD_LAST) state_next = ST_CORI;
            end
            ST_CORI: begin
                cmd.op = OP_COR_INIT;
                step_next = '0;
                state_next = ST_COR;
            end
            ST_COR: begin
                cmd.op = OP_COR_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == COR_LAST) state_next = ST_CORE;
            end
            ST_CORE: begin
                cmd.op = OP_COR_END;
                step_next = '0;
                state_next = ST_PM;
            end
            ST_PM: begin
                cmd.op = OP_MUL_PT;
                state_next = ST_PF;
            end
            ST_PF: begin
                cmd.op = OP_FIELD;
                if (step_reg == PT_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_PM;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.op = OP_ADVANCE;
                    if (st.last_point) state_next = ST_IDLE;
                    else if (st.last_in_ring) state_next = ST_RING;
                    else state_next = ST_CORI;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> rtl/rdl_datapath.sv
`timescale 1ns / 1ps
module rdl_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_fire,
    input  logic [1:0]           cfg_index,
    input  logic [20:0]          cfg_data,
    input  logic signed [31:0]   s_center_x,
    input  logic signed [31:0]   s_center_y,
    input  logic [6:0]           s_point_count,
    input  logic [19:0]          s_symbol_diagonal,
    output logic signed [31:0]   m_symbol_x,
    output logic signed [31:0]   m_symbol_y,
    output logic signed [23:0]   m_label_dx,
    output logic signed [23:0]   m_label_dy,
    output logic [5:0]           m_point_index,
    output logic [5:0]           m_ring_index,
    output logic [23:0]          m_ring_radius,
    output logic                 m_has_circle,
    output logic                 m_last,
    input  rdl_pkg::rdl_cmd_t    cmd,
    output rdl_pkg::rdl_status_t st
);
    import rdl_pkg::*;

    // configuration
    logic               mode_reg;
    logic signed [20:0] gap_reg;
    logic [19:0]        cdiag_reg;

    // group
    logic signed [31:0] cx_reg, cy_reg;
    logic [6:0]         n_reg;
    logic [19:0]        d_reg, half_reg;
    logic signed [31:0] acc_reg, r_reg;
    logic [6:0]         rem_reg, m_reg;
    logic [5:0]         j_reg, k_reg, ring_reg;
    logic signed [63:0] prod_reg;
    // capacity divide
    logic [59:0]        dvn_reg;
    logic [6:0]         q_reg;
    logic               qsat_reg;
    // phase step divide and accumulate
    logic [6:0]         pr_reg;
    logic [31:0]        sq_reg, phase_reg;
    logic [7:0]         frac_reg;
    // CORDIC
    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic signed [19:0] sn_reg, cs_reg;

    logic [6:0]         n_clamp;
    logic [20:0]        first_w;
    logic signed [31:0] gap_ext, lr_w, mul_a, mul_b, fit_w, half_s;
    logic signed [63:0] prod_w, rnd_w;
    logic signed [47:0] v_w;
    logic signed [48:0] sx_w, sy_w;
    logic [56:0]        fit_sum;
    logic [47:0]        div_d;
    logic [59:0]        div_sh;
    logic [4:0]         cap_sh;
    logic [7:0]         pr_t, frac_t;
    logic signed [33:0] dx_w, dy_w, xr_w, yr_w;
    logic signed [19:0] c_w, s_w;
    logic [6:0]         mm_w;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647) return 32'sh7FFFFFFF;
        else if (v < -49'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607) return 24'sh7FFFFF;
        else if (v < -48'sd8388608) return 24'sh800000;
        else return v[23:0];
    endfunction

    assign n_clamp = (s_point_count > 7'(MAX_GROUP)) ? 7'(MAX_GROUP) : s_point_count;
    assign first_w = (21'(cdiag_reg) + 21'(s_symbol_diagonal) + 21'd1) >> 1;
    assign gap_ext = 32'(gap_reg);
    assign half_s  = $signed({12'b0, half_reg});
    assign lr_w    = r_reg + half_s;

    assign st.in_zero      = (s_point_count == 7'd0);
    assign st.in_one       = (s_point_count == 7'd1);
    assign st.mode         = mode_reg;
    assign st.d_zero       = (d_reg == 20'd0);
    assign st.last_point   = ({1'b0, k_reg} + 7'd1 == n_reg);
    assign st.last_in_ring = ({1'b0, j_reg} + 7'd1 == m_reg);

    // shared multiplier operands
    always_comb begin
        mul_a = r_reg;
        mul_b = $signed(TWO_PI_Q28[31:0]);
        case (cmd.op)
            OP_MUL_ND: begin
                mul_a = $signed({25'b0, n_reg});
                mul_b = $signed({12'b0, d_reg});
            end
            OP_MUL_FIT: begin
                mul_a = $signed({6'b0, prod_reg[25:0]});
                mul_b = $signed(INV_TWO_PI_Q32[31:0]);
            end
            OP_MUL_PT: begin
                mul_a = cmd.step[1] ? lr_w : r_reg;
                mul_b = cmd.step[0] ? 32'(cs_reg) : 32'(sn_reg);
            end
            default: begin
                mul_a = r_reg;
                mul_b = $signed(TWO_PI_Q28[31:0]);
            end
        endcase
    end
    assign prod_w = mul_a * mul_b;

    assign fit_sum = prod_reg[56:0] + 57'h80000000;
    assign fit_w   = $signed({7'b0, fit_sum[56:32]});

    assign div_d  = {d_reg, 28'b0};
    assign cap_sh = 5'd6 - cmd.step;
    assign div_sh = {12'b0, div_d} << cap_sh;
    assign mm_w   = qsat_reg ? 7'd127 : ((q_reg == 7'd0) ? 7'd1 : q_reg);

    assign pr_t   = {pr_reg, 1'b0};
    assign frac_t = frac_reg + {1'b0, pr_reg};

    assign dx_w = y_reg >>> cmd.step;
    assign dy_w = x_reg >>> cmd.step;
    assign xr_w = x_reg + 34'sd8192;
    assign yr_w = y_reg + 34'sd8192;
    assign c_w  = xr_w[33:14];
    assign s_w  = yr_w[33:14];

    assign rnd_w = prod_reg + 64'sd32768;
    assign v_w   = rnd_w[63:16];
    assign sx_w  = 49'(cx_reg) + 49'(v_w);
    assign sy_w  = 49'(cy_reg) + 49'(v_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            gap_reg   <= '0;
            cdiag_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_GAP:   gap_reg   <= $signed(cfg_data);
                REG_CDIAG: cdiag_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cx_reg   <= s_center_x;
                cy_reg   <= s_center_y;
                n_reg    <= n_clamp;
                rem_reg  <= n_clamp;
                d_reg    <= s_symbol_diagonal;
                half_reg <= 20'((21'(s_symbol_diagonal) + 21'd1) >> 1);
                acc_reg  <= $signed({11'b0, first_w}) + gap_ext;
                k_reg    <= '0;
                ring_reg <= '0;
            end
            OP_SINGLE: begin
                m_symbol_x    <= cx_reg;
                m_symbol_y    <= cy_reg;
                m_label_dx    <= $signed({4'b0, half_reg});
                m_label_dy    <= -$signed({4'b0, half_reg});
                m_point_index <= '0;
                m_ring_index  <= '0;
                m_ring_radius <= '0;
                m_has_circle  <= 1'b0;
                m_last        <= 1'b1;
            end
            OP_MUL_ND, OP_MUL_FIT, OP_MUL_CAP, OP_MUL_PT: prod_reg <= prod_w;
            OP_SET_R1: begin
                r_reg <= ((fit_w > half_s) ? fit_w : half_s) + gap_ext;
                m_reg <= n_reg;
                j_reg <= '0;
            end
            OP_RING: begin
                r_reg   <= acc_reg[31] ? 32'sd0 : acc_reg;
                acc_reg <= acc_reg + half_s + half_s - 32'(half_reg != 20'd0 && d_reg[0])
                           + gap_ext;
                m_reg   <= rem_reg;
                j_reg   <= '0;
            end
            OP_CAP_CMP: begin
                dvn_reg  <= prod_reg[59:0];
                qsat_reg <= (prod_reg[59:0] >= {5'b0, div_d, 7'b0});
                q_reg    <= '0;
            end
            OP_CAP_STEP: begin
                if (dvn_reg >= div_sh) begin
                    dvn_reg        <= dvn_reg - div_sh;
                    q_reg[cap_sh[2:0]] <= 1'b1;
                end
            end
            OP_CAP_END: m_reg <= (mm_w > rem_reg) ? rem_reg : mm_w;
            OP_PHD_INIT: begin
                pr_reg    <= 7'd1;
                sq_reg    <= '0;
                phase_reg <= '0;
                frac_reg  <= '0;
            end
            OP_PHD_STEP: begin
                if (pr_t >= {1'b0, m_reg}) begin
                    pr_reg <= 7'(pr_t - {1'b0, m_reg});
                    sq_reg <= {sq_reg[30:0], 1'b1};
                end else begin
                    pr_reg <= pr_t[6:0];
                    sq_reg <= {sq_reg[30:0], 1'b0};
                end
            end
            OP_COR_INIT: begin
                x_reg <= GAIN_Q30;
                y_reg <= '0;
                z_reg <= $signed({3'b0, phase_reg[29:0]});
            end
            OP_COR_STEP: begin
                if (!z_reg[32]) begin
                    x_reg <= x_reg - dx_w;
                    y_reg <= y_reg + dy_w;
                    z_reg <= z_reg - $signed({1'b0, atan_turns(cmd.step)});
                end else begin
                    x_reg <= x_reg + dx_w;
                    y_reg <= y_reg - dy_w;
                    z_reg <= z_reg + $signed({1'b0, atan_turns(cmd.step)});
                end
            end
            OP_COR_END: begin
                case (phase_reg[31:30])
                    2'd0: begin cs_reg <= c_w;  sn_reg <= s_w;  end
                    2'd1: begin cs_reg <= -s_w; sn_reg <= c_w;  end
                    2'd2: begin cs_reg <= -c_w; sn_reg <= -s_w; end
                    default: begin cs_reg <= s_w; sn_reg <= -c_w; end
                endcase
                m_point_index <= k_reg;
                m_ring_index  <= ring_reg;
                m_ring_radius <= r_reg[31] ? 24'd0 :
                                 ((r_reg > 32'sh00FFFFFF) ? 24'hFFFFFF : r_reg[23:0]);
                m_has_circle  <= 1'b1;
                m_last        <= st.last_point;
            end
            OP_FIELD: begin
                case (cmd.step[1:0])
                    2'd0: m_symbol_x <= sat32(sx_w);
                    2'd1: m_symbol_y <= sat32(sy_w);
                    2'd2: m_label_dx <= sat24(v_w);
                    default: m_label_dy <= sat24(v_w);
                endcase
            end
            OP_ADVANCE: begin
                k_reg   <= k_reg + 6'd1;
                j_reg   <= j_reg + 6'd1;
                rem_reg <= rem_reg - 7'd1;
                if (st.last_in_ring) ring_reg <= ring_reg + 6'd1;
                if (frac_t >= {1'b0, m_reg}) begin
                    frac_reg  <= frac_t - {1'b0, m_reg};
                    phase_reg <= phase_reg + sq_reg + 32'd1;
                end else begin
                    frac_reg  <= frac_t;
                    phase_reg <= phase_reg + sq_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/ring_displacement_layout.sv
`timescale 1ns / 1ps
// Ring displacement layout. One input transaction describes a group of
// coincident points (centre, count, largest symbol diagonal); the block
// returns one result transaction per point with the displaced symbol
// position, the label offset and the ring radius, the final one flagged
// by m_last. A count of zero returns nothing, a count above 64 is taken as
// 64 and a single point stays at the centre. Groups are handled one at a
// time: s_ready is high only while no group is in progress. Each point
// takes a 16-step CORDIC rotation with its set-up and rounding steps,
// then four passes through one shared 32x32 multiplier, then the
// output handshake; each ring adds the bit-serial angle step division,
// and in concentric mode also the ring radius and the capacity
// division. Configuration writes (index 0 mode, 1 ring gap, 2 centre
// diagonal) are accepted every cycle and must only be issued while the
// block is idle.
module ring_displacement_layout (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [20:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_center_x,
    input  logic signed [31:0]  s_center_y,
    input  logic [6:0]          s_point_count,
    input  logic [19:0]         s_symbol_diagonal,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_symbol_x,
    output logic signed [31:0]  m_symbol_y,
    output logic signed [23:0]  m_label_dx,
    output logic signed [23:0]  m_label_dy,
    output logic [5:0]          m_point_index,
    output logic [5:0]          m_ring_index,
    output logic [23:0]         m_ring_radius,
    output logic                m_has_circle,
    output logic                m_last
);
    import rdl_pkg::*;

    rdl_cmd_t    cmd;
    rdl_status_t st;

    // register writes never stall
    assign cfg_ready = 1'b1;

    rdl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rdl_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_fire          (cfg_valid & cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_center_x        (s_center_x),
        .s_center_y        (s_center_y),
        .s_point_count     (s_point_count),
        .s_symbol_diagonal (s_symbol_diagonal),
        .m_symbol_x        (m_symbol_x),
        .m_symbol_y        (m_symbol_y),
        .m_label_dx        (m_label_dx),
        .m_label_dy        (m_label_dy),
        .m_point_index     (m_point_index),
        .m_ring_index      (m_ring_index),
        .m_ring_radius     (m_ring_radius),
        .m_has_circle      (m_has_circle),
        .m_last            (m_last),
        .cmd               (cmd),
        .st                (st)
    );

    // one group at a time: never offering a result while taking a group
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input taken while a result is pending");

    // an empty group produces no transaction
    a_empty_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_point_count == 7'd0) |=> !m_valid)
        else $error("result produced for an empty group");

    // the block is free again straight after the final point
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid))
        else $error("block busy after final point");

    // a lone point is always the last of its group
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_circle) |-> (m_last && m_point_index == 6'd0))
        else $error("single point not flagged last");

endmodule

>>> dv/rdl_layout_checker.sv
`timescale 1ns / 1ps
module rdl_layout_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [20:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_center_x,
    input  logic signed [31:0] s_center_y,
    input  logic [6:0]         s_point_count,
    input  logic [19:0]        s_symbol_diagonal,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_symbol_x,
    input  logic signed [31:0] m_symbol_y,
    input  logic signed [23:0] m_label_dx,
    input  logic signed [23:0] m_label_dy,
    input  logic [5:0]         m_point_index,
    input  logic [5:0]         m_ring_index,
    input  logic [23:0]        m_ring_radius,
    input  logic               m_has_circle,
    input  logic               m_last,
    output int                 fail_count,
    output int                 pending
);
    import rdl_pkg::*;

    typedef struct {
        logic signed [31:0] sym_x;
        logic signed [31:0] sym_y;
        logic signed [23:0] lbl_dx;
        logic signed [23:0] lbl_dy;
        logic [5:0]         pt_idx;
        logic [5:0]         ring_idx;
        logic [23:0]        radius;
        logic               circle;
        logic               final_pt;
    } layout_point_t;

    localparam longint ATAN_TURNS [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    layout_point_t    expected_points[$];
    logic             mode_q;
    longint           gap_q;
    longint           cdiag_q;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate(logic [31:0] phase, output longint sn,
                                   output longint cs);
        longint x, y, z, dx, dy, c, s;
        x = 64'sd652032874;
        y = 0;
        z = longint'({34'b0, phase[29:0]});
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        case (phase[31:30])
            2'd0:    begin cs = c;  sn = s;  end
            2'd1:    begin cs = -s; sn = c;  end
            2'd2:    begin cs = -c; sn = -s; end
            default: begin cs = s;  sn = -c; end
        endcase
    endfunction

    function automatic layout_point_t place_point(longint cx, longint cy, longint r,
                                                  longint half, logic [31:0] phase,
                                                  int idx, int ring, logic fin);
        layout_point_t p;
        longint sn, cs, lr;
        rotate(phase, sn, cs);
        lr = r + half;
        p.sym_x    = 32'(clamp(cx + ((r * sn + 32768) >>> 16), -64'sd2147483648, 64'sd2147483647));
        p.sym_y    = 32'(clamp(cy + ((r * cs + 32768) >>> 16), -64'sd2147483648, 64'sd2147483647));
        p.lbl_dx   = 24'(clamp((lr * sn + 32768) >>> 16, -64'sd8388608, 64'sd8388607));
        p.lbl_dy   = 24'(clamp((lr * cs + 32768) >>> 16, -64'sd8388608, 64'sd8388607));
        p.pt_idx   = 6'(idx);
        p.ring_idx = 6'(ring);
        p.radius   = 24'(clamp(r, 0, 64'hFFFFFF));
        p.circle   = 1'b1;
        p.final_pt = fin;
        return p;
    endfunction

    function automatic logic [31:0] turn_phase(int j, int m);
        logic [63:0] ph;
        ph = ({32'b0, 32'(j)} << 32) / 64'(m);
        return ph[31:0];
    endfunction

    // queue the points of one group
    function automatic void predict_group(longint cx, longint cy, int cnt, longint d);
        layout_point_t p;
        longint half, fit, r, first;
        logic [63:0] cap;
        int n, k, rem, ring, m;
        n = cnt > MAX_GROUP ? MAX_GROUP : cnt;
        half = (d + 1) >>> 1;
        if (n == 0) return;
        if (n == 1) begin
            p.sym_x = 32'(cx); p.sym_y = 32'(cy);
            p.lbl_dx = 24'(half); p.lbl_dy = 24'(-half);
            p.pt_idx = '0; p.ring_idx = '0; p.radius = '0;
            p.circle = 1'b0; p.final_pt = 1'b1;
            expected_points.push_back(p);
            return;
        end
        if (!mode_q) begin
            fit = longint'((64'(n) * 64'(d) * INV_TWO_PI_Q32 + 64'h80000000) >> 32);
            r = (fit > half ? fit : half) + gap_q;
            for (k = 0; k < n; k++)
                expected_points.push_back(place_point(cx, cy, r, half, turn_phase(k, n),
                                                      k, 0, k + 1 == n));
        end else begin
            rem = n; ring = 0; k = 0;
            first = (cdiag_q + d + 1) >>> 1;
            while (rem > 0 && ring < 64) begin
                r = first + longint'(ring) * d + longint'(ring + 1) * gap_q;
                if (r < 0) r = 0;
                if (d == 0) m = rem;
                else begin
                    cap = (64'(r) * TWO_PI_Q28) / (64'(d) << 28);
                    if (cap < 1) cap = 1;
                    if (cap > 64'(rem)) cap = 64'(rem);
                    m = int'(cap);
                end
                for (int j = 0; j < m; j++, k++)
                    expected_points.push_back(place_point(cx, cy, r, half, turn_phase(j, m),
                                                          k, ring, k + 1 == n));
                rem -= m;
                ring++;
            end
        end
    endfunction

    function automatic void compare(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        layout_point_t e;
        if (!aresetn) begin
            mode_q = 1'b0; gap_q = 0; cdiag_q = 0;
            expected_points.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:  mode_q = cfg_data[0];
                    REG_GAP:   gap_q = longint'($signed(cfg_data));
                    REG_CDIAG: cdiag_q = longint'({44'b0, cfg_data[19:0]});
                    default:   ;
                endcase
            end
            if (s_valid && s_ready)
                predict_group(longint'(s_center_x), longint'(s_center_y),
                              int'(s_point_count), longint'({44'b0, s_symbol_diagonal}));
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("result transaction with no expected point");
                    fail_count++;
                end else begin
                    e = expected_points.pop_front();
                    compare("symbol_x", e.sym_x, m_symbol_x);
                    compare("symbol_y", e.sym_y, m_symbol_y);
                    compare("label_dx", e.lbl_dx, m_label_dx);
                    compare("label_dy", e.lbl_dy, m_label_dy);
                    compare("point_index", e.pt_idx, m_point_index);
                    compare("ring_index", e.ring_idx, m_ring_index);
                    compare("ring_radius", e.radius, m_ring_radius);
                    compare("has_circle", e.circle, m_has_circle);
                    compare("last", e.final_pt, m_last);
                end
            end
        end
        pending <= expected_points.size();
    end

endmodule

>>> dv/tb_ring_displacement_layout.sv
`timescale 1ns / 1ps
module tb_ring_displacement_layout;
    import rdl_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_CYCLES = 80;   // covers a zero-count group still in flight
    localparam int HOLD_CYCLES = 2500;  // long receiver stall
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [20:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_center_x;
    logic signed [31:0] s_center_y;
    logic [6:0]         s_point_count;
    logic [19:0]        s_symbol_diagonal;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_symbol_x;
    logic signed [31:0] m_symbol_y;
    logic signed [23:0] m_label_dx;
    logic signed [23:0] m_label_dy;
    logic [5:0]         m_point_index;
    logic [5:0]         m_ring_index;
    logic [23:0]        m_ring_radius;
    logic               m_has_circle;
    logic               m_last;

    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    bit                 no_idle;        // both sides run flat out while set
    bit                 hold_request;   // asks the receiver for a long stall

    ring_displacement_layout i_dut (.*);

    rdl_layout_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop on a hung block
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !no_idle && $urandom_range(99) < 19;
    endfunction

    // receiver: random back-pressure, plus one long hold when asked
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !idle_now();
        end
    end

    // one group transaction; valid stays high into the next one if no gap
    task automatic send_group(logic signed [31:0] cx, logic signed [31:0] cy,
                              logic [6:0] cnt, logic [19:0] diag);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_center_x        <= cx;
        s_center_y        <= cy;
        s_point_count     <= cnt;
        s_symbol_diagonal <= diag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and wait for the block to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [20:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // all three registers back to back, valid lowered only at the end
    task automatic configure(logic mode, logic [20:0] gap, logic [19:0] cdiag);
        cfg_write(REG_MODE, {20'b0, mode});
        cfg_write(REG_GAP, gap);
        cfg_write(REG_CDIAG, {1'b0, cdiag});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_group();
        logic signed [31:0] cx, cy;
        logic [6:0]         cnt;
        logic [19:0]        diag;
        int                 sel;
        sel = $urandom_range(99);
        if (sel < 8)       cnt = 7'd0;
        else if (sel < 20) cnt = 7'd1;
        else if (sel < 85) cnt = 7'($urandom_range(2, 8));
        else if (sel < 95) cnt = 7'($urandom_range(9, 24));
        else               cnt = 7'($urandom_range(25, 127));
        sel = $urandom_range(99);
        if (sel < 50)      diag = 20'($urandom_range(1, 4096));
        else if (sel < 90) diag = 20'($urandom);
        else               diag = '0;
        if ($urandom_range(99) < 70) begin
            cx = 32'($signed(21'($urandom)));
            cy = 32'($signed(21'($urandom)));
        end else begin
            cx = $urandom;
            cy = $urandom;
        end
        send_group(cx, cy, cnt, diag);
    endtask

    initial begin
        aresetn           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        s_valid           <= 1'b0;
        s_center_x        <= '0;
        s_center_y        <= '0;
        s_point_count     <= '0;
        s_symbol_diagonal <= '0;
        no_idle           = 1'b0;
        hold_request      = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (5) @(posedge aclk);

        // directed, reset register values: single ring, no gap
        send_group(32'sd0, 32'sd0, 7'd0, 20'd100);           // empty group
        send_group(32'sd1000, -32'sd1000, 7'd1, 20'hFFFFF);  // lone point, widest symbol
        send_group(32'sd0, 32'sd0, 7'd2, 20'd512);
        send_group(32'sd0, 32'sd0, 7'd3, 20'd0);             // zero diagonal
        send_group(32'h7FFFFFFF, 32'h80000000, 7'd4, 20'hFFFFF); // saturating centre
        send_group(32'h80000000, 32'h7FFFFFFF, 7'd64, 20'd256);  // full group
        send_group(32'sd5, 32'sd7, 7'd127, 20'd64);          // over-size count, clipped
        send_group(32'sd0, 32'sd0, 7'd65, 20'hFFFFF);
        settle();

        // negative ring gap flips the points to the far side
        configure(1'b0, 21'h100000, 20'd0);
        send_group(32'sd0, 32'sd0, 7'd5, 20'd300);
        send_group(32'sd0, 32'sd0, 7'd1, 20'd0);
        settle();

        // concentric rings, extreme centre marker and gaps
        configure(1'b1, 21'h0FFFFF, 20'hFFFFF);
        send_group(32'sd100, 32'sd100, 7'd64, 20'hFFFFF);
        send_group(32'sd0, 32'sd0, 7'd12, 20'd0);            // zero diagonal, one ring
        settle();
        configure(1'b1, 21'h100000, 20'd0);                  // radius clamps at zero
        send_group(32'sd0, 32'sd0, 7'd10, 20'd200);
        settle();
        configure(1'b1, 21'd0, 20'd1024);
        cfg_write(REG_UNMAPPED, 21'h1FFFFF);                  // unmapped index, ignored
        cfg_valid <= 1'b0;
        send_group(-32'sd300, 32'sd300, 7'd40, 20'd256);
        send_group(32'sd0, 32'sd0, 7'd7, 20'd1);
        settle();

        // random phases under random settings
        for (int ph = 0; ph < 4; ph++) begin
            if ($urandom_range(1))
                configure(1'($urandom), 21'($urandom), 20'($urandom));
            else
                configure(1'($urandom), 21'($signed(12'($urandom))), 20'($urandom_range(0, 8192)));
            for (int i = 0; i < 24; i++) begin
                no_idle = (ph == 1 && i >= 4 && i < 20);
                if (ph == 2 && i == 3) begin
                    // stall the receiver on a big group while more are offered
                    hold_request = 1'b1;
                    send_group(32'sd0, 32'sd0, 7'd64, 20'd128);
                end
                random_group();
            end
            no_idle = 1'b0;
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
